>>> hdl/pressure_temperature_compensation_unit_macros.svh
// Assertion macros shared by the pressure/temperature compensation RTL.
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_UNIT_MACROS_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_UNIT_MACROS_SVH

// Same-cycle implication, checked on clk, off while rst_n is low.
`define PTC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ptc assertion failed");

// Next-cycle implication, checked on clk, off while rst_n is low.
`define PTC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ptc assertion failed");

`endif

>>> hdl/ptc_pkg.sv
// Package: types, constants and helpers of the compensation pipeline.
`timescale 1ns / 1ps
package ptc_pkg;

  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_COEFFS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LOW   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_MID   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_HIGH  = 4'd3;

  localparam int DIV_BITS_PER_STAGE = 2;
  localparam int DIV_STAGES = 64 / DIV_BITS_PER_STAGE;

  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } ptc_coef_t;

  typedef struct packed {
    logic [31:0] tc;
    logic [31:0] fine;
    logic        invalid;
  } ptc_side_t;

  typedef struct packed {
    logic [31:0] tc;
    logic [31:0] fine;
    logic [31:0] press;
    logic        invalid;
  } ptc_res_t;

  // Unsigned 32-bit word times signed 16-bit coefficient, exact.
  function automatic logic signed [48:0] ptc_mul_us(input logic [31:0] x,
                                                    input logic signed [15:0] c);
    return $signed({1'b0, x}) * c;
  endfunction

  // Sign-extend a 49-bit partial product to 64 bits.
  function automatic logic [63:0] ptc_sx49(input logic [48:0] x);
    return {{15{x[48]}}, x};
  endfunction

endpackage

>>> hdl/ptc_temp.sv
// Temperature compensation stages: fine temperature, centidegrees, pressure offset.
`timescale 1ns / 1ps
module ptc_temp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [19:0]         raw_temp,
  input  logic [19:0]         raw_press,
  input  ptc_pkg::ptc_coef_t  coef,
  output logic                out_valid,
  output ptc_pkg::ptc_side_t  side,
  output logic signed [32:0]  v1,
  output logic [19:0]         raw_press_o
);

  logic [4:0] v_r;
  logic [19:0] rp_r [0:4];

  logic signed [17:0] x1_r, x1_nxt;
  logic signed [16:0] dd_r, dd_nxt;
  logic signed [33:0] pa_r, pa_nxt;
  logic signed [33:0] dsq_r, dsq_nxt;
  logic signed [31:0] a_nxt;
  logic signed [35:0] pb_r, pb_nxt;
  logic signed [31:0] a4_r;
  logic [31:0] fine_r, fine_nxt;
  logic [31:0] tc_r, tc_nxt;
  logic [31:0] fine5_r;
  logic signed [32:0] v1_r, v1_nxt;

  always_comb begin
    logic signed [31:0] b0;
    logic [31:0] tcs;
    x1_nxt = $signed({1'b0, raw_temp[19:3]}) - $signed({1'b0, coef.t1, 1'b0});
    dd_nxt = $signed({1'b0, raw_temp[19:4]}) - $signed({1'b0, coef.t1});
    pa_nxt = x1_r * $signed(coef.t2);
    dsq_nxt = dd_r * dd_r;
    a_nxt = $signed(pa_r[31:0]) >>> 11;
    b0 = $signed(dsq_r[31:0]) >>> 12;
    pb_nxt = $signed(b0[19:0]) * $signed(coef.t3);
    fine_nxt = a4_r + 32'($signed(pb_r[31:0]) >>> 14);
    tcs = fine_r + {fine_r[29:0], 2'b00} + 32'd128;
    tc_nxt = $signed(tcs) >>> 8;
    v1_nxt = $signed({fine_r[31], fine_r} - 33'd128000);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rp_r[0] <= raw_press;
      for (int i = 1; i < 5; i++) rp_r[i] <= rp_r[i-1];
      x1_r <= x1_nxt;
      dd_r <= dd_nxt;
      pa_r <= pa_nxt;
      dsq_r <= dsq_nxt;
      a4_r <= a_nxt;
      pb_r <= pb_nxt;
      fine_r <= fine_nxt;
      tc_r <= tc_nxt;
      fine5_r <= fine_r;
      v1_r <= v1_nxt;
    end
  end

  assign out_valid = v_r[4];
  assign side.tc = tc_r;
  assign side.fine = fine5_r;
  assign side.invalid = 1'b0;
  assign v1 = v1_r;
  assign raw_press_o = rp_r[4];

endmodule

>>> hdl/ptc_press_pre.sv
// Pressure front stages: divisor and numerator of the compensation division.
`timescale 1ns / 1ps
module ptc_press_pre (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  ptc_pkg::ptc_side_t  side_in,
  input  logic signed [32:0]  v1,
  input  logic [19:0]         raw_press,
  input  ptc_pkg::ptc_coef_t  coef,
  output logic                out_valid,
  output ptc_pkg::ptc_side_t  side,
  output logic [63:0]         num,
  output logic signed [30:0]  den
);

  logic [5:0] v_r;
  ptc_pkg::ptc_side_t side_r [0:5];

  logic [63:0] sq_r, sq_nxt;
  logic signed [48:0] mp5_r, mp5_nxt, mp2_r, mp2_nxt;
  logic [20:0] pnum_r [0:2];
  logic [48:0] s6lo_r, s6lo_nxt, s3lo_r, s3lo_nxt;
  logic [31:0] s6hi_r, s6hi_nxt, s3hi_r, s3hi_nxt;
  logic [48:0] mp5b_r, mp2b_r;
  logic [63:0] v2_r, v2_nxt, v1b_r, v1b_nxt;
  logic [63:0] x_r, x_nxt, m_r, m_nxt;
  logic [47:0] xlo_r, xlo_nxt;
  logic [31:0] xhi_r, xhi_nxt;
  logic [43:0] mlo_r, mlo_nxt;
  logic [31:0] mhi_r, mhi_nxt;
  logic [63:0] num_r, num_nxt;
  logic signed [30:0] den_r, den_nxt;

  always_comb begin
    logic signed [65:0] sqf;
    logic [48:0] t6h, t3h;
    logic [63:0] u3, u3s, pr;
    logic [63:0] xh, mh;
    sqf = v1 * v1;
    sq_nxt = sqf[63:0];
    mp5_nxt = v1 * $signed(coef.p5);
    mp2_nxt = v1 * $signed(coef.p2);
    s6lo_nxt = ptc_pkg::ptc_mul_us(sq_r[31:0], coef.p6);
    t6h = ptc_pkg::ptc_mul_us(sq_r[63:32], coef.p6);
    s6hi_nxt = t6h[31:0];
    s3lo_nxt = ptc_pkg::ptc_mul_us(sq_r[31:0], coef.p3);
    t3h = ptc_pkg::ptc_mul_us(sq_r[63:32], coef.p3);
    s3hi_nxt = t3h[31:0];
    v2_nxt = ptc_pkg::ptc_sx49(s6lo_r) + {s6hi_r, 32'd0}
           + {mp5b_r[46:0], 17'd0}
           + {{13{coef.p4[15]}}, coef.p4, 35'd0};
    u3 = ptc_pkg::ptc_sx49(s3lo_r) + {s3hi_r, 32'd0};
    u3s = $signed(u3) >>> 8;
    v1b_nxt = u3s + {{3{mp2b_r[48]}}, mp2b_r, 12'd0};
    x_nxt = 64'h0000_8000_0000_0000 + v1b_r;
    m_nxt = {12'd0, pnum_r[2], 31'd0} - v2_r;
    xlo_nxt = x_r[31:0] * coef.p1;
    xh = {32'd0, x_r[63:32]} * {48'd0, coef.p1};
    xhi_nxt = xh[31:0];
    mlo_nxt = m_r[31:0] * 12'd3125;
    mh = {32'd0, m_r[63:32]} * 64'd3125;
    mhi_nxt = mh[31:0];
    pr = {16'd0, xlo_r} + {xhi_r, 32'd0};
    den_nxt = $signed(pr[63:33]);
    num_nxt = {20'd0, mlo_r} + {mhi_r, 32'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_in;
      for (int i = 1; i < 5; i++) side_r[i] <= side_r[i-1];
      side_r[5] <= {side_r[4].tc, side_r[4].fine, den_nxt == '0};
      sq_r <= sq_nxt;
      mp5_r <= mp5_nxt;
      mp2_r <= mp2_nxt;
      pnum_r[0] <= 21'h100000 - {1'b0, raw_press};
      pnum_r[1] <= pnum_r[0];
      pnum_r[2] <= pnum_r[1];
      s6lo_r <= s6lo_nxt;
      s6hi_r <= s6hi_nxt;
      s3lo_r <= s3lo_nxt;
      s3hi_r <= s3hi_nxt;
      mp5b_r <= mp5_r;
      mp2b_r <= mp2_r;
      v2_r <= v2_nxt;
      v1b_r <= v1b_nxt;
      x_r <= x_nxt;
      m_r <= m_nxt;
      xlo_r <= xlo_nxt;
      xhi_r <= xhi_nxt;
      mlo_r <= mlo_nxt;
      mhi_r <= mhi_nxt;
      num_r <= num_nxt;
      den_r <= den_nxt;
    end
  end

  assign out_valid = v_r[5];
  assign side = side_r[5];
  assign num = num_r;
  assign den = den_r;

endmodule

>>> hdl/ptc_div.sv
// Pipelined signed division: sign removal then restoring stages, two bits each.
`timescale 1ns / 1ps
module ptc_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  ptc_pkg::ptc_side_t  side_in,
  input  logic [63:0]         num,
  input  logic signed [30:0]  den,
  output logic                out_valid,
  output ptc_pkg::ptc_side_t  side,
  output logic [63:0]         mag,
  output logic                neg
);

  localparam int NS = ptc_pkg::DIV_STAGES;

  logic [NS:0] v_r;
  logic [30:0] rem_r [0:NS];
  logic [63:0] dq_r [0:NS];
  logic [30:0] ad_r [0:NS];
  logic neg_r [0:NS];
  ptc_pkg::ptc_side_t side_r [0:NS];

  logic [30:0] rem_c [0:NS-1];
  logic [63:0] dq_c [0:NS-1];

  always_comb begin
    logic [31:0] t;
    for (int k = 0; k < NS; k++) begin
      rem_c[k] = rem_r[k];
      dq_c[k] = dq_r[k];
      for (int j = 0; j < ptc_pkg::DIV_BITS_PER_STAGE; j++) begin
        t = {rem_c[k], dq_c[k][63]};
        if (t >= {1'b0, ad_r[k]}) begin
          rem_c[k] = 31'(t - {1'b0, ad_r[k]});
          dq_c[k] = {dq_c[k][62:0], 1'b1};
        end else begin
          rem_c[k] = t[30:0];
          dq_c[k] = {dq_c[k][62:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NS-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= '0;
      dq_r[0] <= num[63] ? (64'd0 - num) : num;
      ad_r[0] <= den[30] ? 31'(31'd0 - den) : den;
      neg_r[0] <= num[63] ^ den[30];
      side_r[0] <= side_in;
      for (int k = 0; k < NS; k++) begin
        rem_r[k+1] <= rem_c[k];
        dq_r[k+1] <= dq_c[k];
        ad_r[k+1] <= ad_r[k];
        neg_r[k+1] <= neg_r[k];
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign out_valid = v_r[NS];
  assign side = side_r[NS];
  assign mag = dq_r[NS];
  assign neg = neg_r[NS];

endmodule

>>> hdl/ptc_press_post.sv
// Pressure back stages: quadratic correction, offset and Q24.8 result.
`timescale 1ns / 1ps
module ptc_press_post (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  ptc_pkg::ptc_side_t  side_in,
  input  logic [63:0]         mag,
  input  logic                neg,
  input  ptc_pkg::ptc_coef_t  coef,
  output logic                out_valid,
  output ptc_pkg::ptc_res_t   res
);

  logic [5:0] v_r;
  ptc_pkg::ptc_side_t side_r [0:5];
  logic [63:0] q_r [0:3];
  logic [63:0] aa_r, aa_nxt;
  logic [31:0] ab_r, ab_nxt;
  logic [48:0] m8lo_r, m8lo_nxt;
  logic [31:0] m8hi_r, m8hi_nxt;
  logic [63:0] sq_r, sq_nxt;
  logic [63:0] w2_r [0:1];
  logic [63:0] w2_nxt;
  logic [48:0] s9lo_r, s9lo_nxt;
  logic [31:0] s9hi_r, s9hi_nxt;
  logic [63:0] sum_r, sum_nxt;
  logic [31:0] press_r, press_nxt;

  always_comb begin
    logic [63:0] ps, ab64, m8, s9, w1, pf;
    logic [48:0] t8h, t9h;
    ps = $signed(q_r[0]) >>> 13;
    aa_nxt = {32'd0, ps[31:0]} * {32'd0, ps[31:0]};
    ab64 = {32'd0, ps[31:0]} * {32'd0, ps[63:32]};
    ab_nxt = ab64[31:0];
    m8lo_nxt = ptc_pkg::ptc_mul_us(q_r[0][31:0], coef.p8);
    t8h = ptc_pkg::ptc_mul_us(q_r[0][63:32], coef.p8);
    m8hi_nxt = t8h[31:0];
    sq_nxt = aa_r + {ab_r[30:0], 1'b0, 32'd0};
    m8 = ptc_pkg::ptc_sx49(m8lo_r) + {m8hi_r, 32'd0};
    w2_nxt = $signed(m8) >>> 19;
    s9lo_nxt = ptc_pkg::ptc_mul_us(sq_r[31:0], coef.p9);
    t9h = ptc_pkg::ptc_mul_us(sq_r[63:32], coef.p9);
    s9hi_nxt = t9h[31:0];
    s9 = ptc_pkg::ptc_sx49(s9lo_r) + {s9hi_r, 32'd0};
    w1 = $signed(s9) >>> 25;
    sum_nxt = q_r[3] + w1 + w2_r[1];
    pf = ($signed(sum_r) >>> 8) + {{44{coef.p7[15]}}, coef.p7, 4'd0};
    press_nxt = side_r[4].invalid ? 32'd0 : pf[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_in;
      for (int i = 1; i < 6; i++) side_r[i] <= side_r[i-1];
      q_r[0] <= neg ? (64'd0 - mag) : mag;
      for (int i = 1; i < 4; i++) q_r[i] <= q_r[i-1];
      aa_r <= aa_nxt;
      ab_r <= ab_nxt;
      m8lo_r <= m8lo_nxt;
      m8hi_r <= m8hi_nxt;
      sq_r <= sq_nxt;
      w2_r[0] <= w2_nxt;
      w2_r[1] <= w2_r[0];
      s9lo_r <= s9lo_nxt;
      s9hi_r <= s9hi_nxt;
      sum_r <= sum_nxt;
      press_r <= press_nxt;
    end
  end

  assign out_valid = v_r[5];
  assign res.tc = side_r[5].tc;
  assign res.fine = side_r[5].fine;
  assign res.invalid = side_r[5].invalid;
  assign res.press = press_r;

endmodule

>>> hdl/pressure_temperature_compensation_unit.sv
// Top level: calibration registers, compensation pipeline and output skid buffer.
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready   | in_raw_temp, in_raw_press
//  out_    | output    | out_valid / out_ready | temp_centi, fine_temp, press_q24_8,
//          |           |                       | press_invalid
//  cfg_    | input     | cfg_we                | cfg_index, cfg_data
//
// One beat accepted per cycle while the skid register is empty.
// The pipeline is the 32-stage divider (two quotient bits per stage) plus
// 18 arithmetic stages and the output register.
// Synchronous active-low reset clears valid bits and calibration registers.
// A stalled output parks one result in the skid register; the pipeline then holds.
`timescale 1ns / 1ps
`include "pressure_temperature_compensation_unit_macros.svh"
module pressure_temperature_compensation_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [19:0]                       in_raw_temp,
  input  logic [19:0]                       in_raw_press,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [31:0]                out_temp_centi,
  output logic signed [31:0]                out_fine_temp,
  output logic [31:0]                       out_press_q24_8,
  output logic                              out_press_invalid,
  input  logic                              cfg_we,
  input  logic [ptc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ptc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [47:0] temp_coeffs_r, press_low_r, press_mid_r, press_high_r;
  ptc_pkg::ptc_coef_t coef;

  logic en;
  logic t_v, p_v, d_v, pipe_v;
  ptc_pkg::ptc_side_t t_side, p_side, d_side;
  logic signed [32:0] t_v1;
  logic [19:0] t_rp;
  logic [63:0] p_num, d_mag;
  logic signed [30:0] p_den;
  logic d_neg;
  ptc_pkg::ptc_res_t pipe_res;

  logic out_v_r, skid_v_r;
  ptc_pkg::ptc_res_t out_r, skid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_coeffs_r <= '0;
      press_low_r <= '0;
      press_mid_r <= '0;
      press_high_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ptc_pkg::CFG_TEMP_COEFFS: temp_coeffs_r <= cfg_data;
        ptc_pkg::CFG_PRESS_LOW:   press_low_r <= cfg_data;
        ptc_pkg::CFG_PRESS_MID:   press_mid_r <= cfg_data;
        ptc_pkg::CFG_PRESS_HIGH:  press_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign coef.t1 = temp_coeffs_r[15:0];
  assign coef.t2 = temp_coeffs_r[31:16];
  assign coef.t3 = temp_coeffs_r[47:32];
  assign coef.p1 = press_low_r[15:0];
  assign coef.p2 = press_low_r[31:16];
  assign coef.p3 = press_low_r[47:32];
  assign coef.p4 = press_mid_r[15:0];
  assign coef.p5 = press_mid_r[31:16];
  assign coef.p6 = press_mid_r[47:32];
  assign coef.p7 = press_high_r[15:0];
  assign coef.p8 = press_high_r[31:16];
  assign coef.p9 = press_high_r[47:32];

  assign en = !skid_v_r;
  assign in_ready = en;

  ptc_temp u_temp (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid),
    .raw_temp(in_raw_temp), .raw_press(in_raw_press), .coef(coef),
    .out_valid(t_v), .side(t_side), .v1(t_v1), .raw_press_o(t_rp)
  );

  ptc_press_pre u_pre (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(t_v), .side_in(t_side),
    .v1(t_v1), .raw_press(t_rp), .coef(coef),
    .out_valid(p_v), .side(p_side), .num(p_num), .den(p_den)
  );

  ptc_div u_div (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(p_v), .side_in(p_side),
    .num(p_num), .den(p_den),
    .out_valid(d_v), .side(d_side), .mag(d_mag), .neg(d_neg)
  );

  ptc_press_post u_post (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(d_v), .side_in(d_side),
    .mag(d_mag), .neg(d_neg), .coef(coef),
    .out_valid(pipe_v), .res(pipe_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_ready) begin
      if (skid_v_r) begin
        out_r <= skid_r;
        out_v_r <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_r <= pipe_res;
        out_v_r <= pipe_v;
      end
    end else if (pipe_v && !skid_v_r) begin
      skid_r <= pipe_res;
      skid_v_r <= 1'b1;
    end
  end

  assign out_valid = out_v_r;
  assign out_temp_centi = out_r.tc;
  assign out_fine_temp = out_r.fine;
  assign out_press_q24_8 = out_r.press;
  assign out_press_invalid = out_r.invalid;

  `PTC_ASSERT_IMPL(a_skid_needs_out, skid_v_r, out_v_r)
  `PTC_ASSERT_NEXT(a_stall_fills_skid, pipe_v && !skid_v_r && out_v_r && !out_ready, skid_v_r)
  `PTC_ASSERT_NEXT(a_skid_drains, skid_v_r && out_ready, !skid_v_r && out_v_r)
  `PTC_ASSERT_IMPL(a_invalid_zero, out_v_r && out_r.invalid, out_r.press == 32'd0)

endmodule
